// File: rtl/svs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svs_pkg
// Types, register indexes and constants of the sprite vertex to screen
// transform: Q16.8 coordinates, Q8.8 scale, Q2.14 trig and a CORDIC table.
// ----------------------------------------------------------------------------
package svs_pkg;

	localparam int TRIG_TABLE_BITS = 10;
	localparam int ANGLE_DROP      = 16 - TRIG_TABLE_BITS;
	localparam logic [15:0] ANGLE_MASK = 16'hFFFF << ANGLE_DROP;

	localparam int CORDIC_ITERS     = 16;
	localparam int ITERS_PER_STAGE  = 4;
	localparam int CORDIC_STAGES    = CORDIC_ITERS / ITERS_PER_STAGE;
	localparam logic signed [17:0] CORDIC_X0 = 18'sd9949;
	localparam logic signed [15:0] TRIG_ONE  = 16'sd16384;

	localparam logic signed [32:0] ATAN_TURNS [CORDIC_ITERS] = '{
		33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004757,
		33'sd42667330,  33'sd21354466,  33'sd10679839,  33'sd5340245,
		33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
		33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861
	};

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHAKE_X       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHAKE_Y       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;

	localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd720;

	localparam logic signed [39:0] OUT_MAX = 40'sd8388607;
	localparam logic signed [39:0] OUT_MIN = -40'sd8388608;

	typedef struct packed {
		logic signed [23:0] local_x;
		logic signed [23:0] local_y;
		logic signed [15:0] scale_x;
		logic signed [15:0] scale_y;
		logic        [15:0] angle;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
	} vertex_t;

	typedef struct packed {
		logic signed [23:0] screen_x;
		logic signed [23:0] screen_y;
	} point_t;

	typedef struct packed {
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [32:0] z;
	} cordic_t;

	typedef struct packed {
		logic signed [39:0] ax;
		logic signed [39:0] ay;
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic        [1:0]  quad;
		logic               rzero;
	} carry_t;

	function automatic logic signed [15:0] trig_clamp(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'(TRIG_ONE))
			r = TRIG_ONE;
		else if (v < -18'(TRIG_ONE))
			r = -TRIG_ONE;
		else
			r = v[15:0];
		return r;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
		logic signed [23:0] r;
		if (v > OUT_MAX)
			r = OUT_MAX[23:0];
		else if (v < OUT_MIN)
			r = OUT_MIN[23:0];
		else
			r = v[23:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/sprite_vertex_to_screen.sv
`default_nettype none
// Throughput: one vertex per cycle; busy stays low.
// The latency is set by the CORDIC (four stages of four iterations) and the
// multiply, sum and saturate stages behind it.
// Reset clears all valid bits and returns the config registers to their defaults.
// Results cannot be held off by the receiver; done marks each for one cycle.
// ----------------------------------------------------------------------------
// sprite_vertex_to_screen
// Scale, rotate and translate a sprite vertex, subtract camera plus shake
// and flip y against the screen height. Pipelined CORDIC sine and cosine.
// ----------------------------------------------------------------------------
module sprite_vertex_to_screen (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output      logic                            busy,
	input  wire svs_pkg::vertex_t                vertex,
	output      logic                            done,
	output      svs_pkg::point_t                 pix,
	input  wire logic                            cfg_we,
	input  wire logic [svs_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [svs_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import svs_pkg::*;

	logic signed [23:0] cam_x_q, cam_y_q, shk_x_q, shk_y_q;
	logic        [11:0] height_q;
	logic signed [24:0] csum_x, csum_y;

	logic        accept;
	logic [15:0] angle_t;
	logic [13:0] resid;

	cordic_t cord_s  [CORDIC_STAGES+1];
	carry_t  carry_s [CORDIC_STAGES+1];
	logic    vc_s    [CORDIC_STAGES+1];

	logic               v_s6, v_s7, v_s8, v_s9, v_s10;
	logic signed [15:0] cos_s6, sin_s6;
	logic signed [39:0] ax_s6, ay_s6;
	logic signed [23:0] px_s6, py_s6, px_s7, py_s7;
	logic signed [55:0] axc_s7, ays_s7, axs_s7, ayc_s7;
	logic signed [36:0] wx_s8, wy_s8;
	logic signed [37:0] vx_s9, vy_s9;
	point_t             pix_s10;

	logic signed [15:0] c_pre, s_pre, cos_n, sin_n;
	logic signed [57:0] sx_n, sy_n;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q  <= '0;
			cam_y_q  <= '0;
			shk_x_q  <= '0;
			shk_y_q  <= '0;
			height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CAMERA_X:      cam_x_q  <= cfg_data;
				REG_CAMERA_Y:      cam_y_q  <= cfg_data;
				REG_SHAKE_X:       shk_x_q  <= cfg_data;
				REG_SHAKE_Y:       shk_y_q  <= cfg_data;
				// width cancels out of the viewport map: drop
				REG_SCREEN_WIDTH:  ;
				REG_SCREEN_HEIGHT: height_q <= cfg_data[11:0];
				default:           ;
			endcase
		end
	end

	assign csum_x = 25'(cam_x_q) + 25'(shk_x_q);
	assign csum_y = 25'(cam_y_q) + 25'(shk_y_q);

	// stage 1: capture, scale products, CORDIC seed
	assign angle_t = vertex.angle & ANGLE_MASK;
	assign resid   = angle_t[13:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vc_s[0] <= 1'b0;
		else
			vc_s[0] <= accept;
	end

	always_ff @(posedge clk) begin
		cord_s[0].x        <= CORDIC_X0;
		cord_s[0].y        <= '0;
		cord_s[0].z        <= 33'(resid) <<< 16;
		carry_s[0].ax      <= 40'(vertex.local_x) * 40'(vertex.scale_x);
		carry_s[0].ay      <= 40'(vertex.local_y) * 40'(vertex.scale_y);
		carry_s[0].px      <= vertex.pos_x;
		carry_s[0].py      <= vertex.pos_y;
		carry_s[0].quad    <= angle_t[15:14];
		carry_s[0].rzero   <= (resid == '0);
	end

	// stages 2 to 5: CORDIC rotation
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		cordic_t nxt;

		always_comb begin
			logic signed [17:0] dx;
			logic signed [17:0] dy;
			nxt = cord_s[g];
			for (int j = 0; j < ITERS_PER_STAGE; j++) begin
				dx = nxt.y >>> (g * ITERS_PER_STAGE + j);
				dy = nxt.x >>> (g * ITERS_PER_STAGE + j);
				if (!nxt.z[32]) begin
					nxt.x = nxt.x - dx;
					nxt.y = nxt.y + dy;
					nxt.z = nxt.z - ATAN_TURNS[g * ITERS_PER_STAGE + j];
				end else begin
					nxt.x = nxt.x + dx;
					nxt.y = nxt.y - dy;
					nxt.z = nxt.z + ATAN_TURNS[g * ITERS_PER_STAGE + j];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vc_s[g+1] <= 1'b0;
			else
				vc_s[g+1] <= vc_s[g];
		end

		always_ff @(posedge clk) begin
			cord_s[g+1]  <= nxt;
			carry_s[g+1] <= carry_s[g];
		end
	end

	// stage 6: clamp and quadrant map
	always_comb begin
		if (carry_s[CORDIC_STAGES].rzero) begin
			c_pre = TRIG_ONE;
			s_pre = '0;
		end else begin
			c_pre = trig_clamp(cord_s[CORDIC_STAGES].x);
			s_pre = trig_clamp(cord_s[CORDIC_STAGES].y);
		end
		case (carry_s[CORDIC_STAGES].quad)
			QUAD_1: begin
				cos_n = -s_pre;
				sin_n = c_pre;
			end
			QUAD_2: begin
				cos_n = -c_pre;
				sin_n = -s_pre;
			end
			QUAD_3: begin
				cos_n = s_pre;
				sin_n = -c_pre;
			end
			default: begin
				cos_n = c_pre;
				sin_n = s_pre;
			end
		endcase
	end

	// stage 7: rotation products; stage 8: round and translate
	assign sx_n = 58'(axc_s7) - 58'(ays_s7) + (58'sd1 <<< 21);
	assign sy_n = 58'(axs_s7) + 58'(ayc_s7) + (58'sd1 <<< 21);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			v_s6  <= vc_s[CORDIC_STAGES];
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		cos_s6 <= cos_n;
		sin_s6 <= sin_n;
		ax_s6  <= carry_s[CORDIC_STAGES].ax;
		ay_s6  <= carry_s[CORDIC_STAGES].ay;
		px_s6  <= carry_s[CORDIC_STAGES].px;
		py_s6  <= carry_s[CORDIC_STAGES].py;

		axc_s7 <= 56'(ax_s6) * 56'(cos_s6);
		ays_s7 <= 56'(ay_s6) * 56'(sin_s6);
		axs_s7 <= 56'(ax_s6) * 56'(sin_s6);
		ayc_s7 <= 56'(ay_s6) * 56'(cos_s6);
		px_s7  <= px_s6;
		py_s7  <= py_s6;

		wx_s8  <= 37'($signed(sx_n[57:22])) + 37'(px_s7);
		wy_s8  <= 37'($signed(sy_n[57:22])) + 37'(py_s7);

		vx_s9  <= 38'(wx_s8) - 38'(csum_x);
		vy_s9  <= 38'(wy_s8) - 38'(csum_y);

		pix_s10.screen_x <= sat24(40'(vx_s9));
		pix_s10.screen_y <= sat24(40'(signed'({1'b0, height_q, 8'h00})) - 40'(vy_s9));
	end

	assign done = v_s10;
	assign pix  = pix_s10;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vc_s[0], 9))
		else $error("result without a transfer nine cycles earlier");

	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> (cos_s6 <= TRIG_ONE) && (cos_s6 >= -TRIG_ONE) &&
			(sin_s6 <= TRIG_ONE) && (sin_s6 >= -TRIG_ONE))
		else $error("trig value outside unit range");

	a_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		vc_s[CORDIC_STAGES] && carry_s[CORDIC_STAGES].rzero &&
			(carry_s[CORDIC_STAGES].quad == QUAD_0) |=>
			(cos_s6 == TRIG_ONE) && (sin_s6 == 16'sd0))
		else $error("zero angle did not give identity rotation");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vc_s[0] |-> $past(start))
		else $error("pipeline entry without start");

endmodule
`default_nettype wire

// File: bench/sprite_vertex_to_screen_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_vertex_to_screen_tb
// Streams sprite vertices through the block and checks every screen point.
// The expected point is computed on the bench with its own CORDIC and
// fixed-point math. Camera, shake and screen registers change only between
// runs, with the block drained. Sender gaps vary between runs.
// ----------------------------------------------------------------------------
module sprite_vertex_to_screen_tb;
	import svs_pkg::*;

	localparam logic [23:0] COORD_MAX = 24'h7FFFFF;
	localparam logic [23:0] COORD_MIN = 24'h800000;
	localparam logic [15:0] SCALE_MAX = 16'h7FFF;
	localparam logic [15:0] SCALE_MIN = 16'h8000;
	localparam logic [15:0] SCALE_ONE = 16'd256;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;
	localparam longint ROT_X_START = 9949;
	localparam longint ROT_UNIT    = 16384;
	localparam longint ROUND_HALF  = 64'sd2097152;
	localparam longint SCREEN_MAX  = 8388607;
	localparam longint SCREEN_MIN  = -8388608;
	localparam int     DRAIN_LIMIT = 200;
	localparam int     FLUSH_CYCLES = 16;
	localparam longint ROT_ATAN [16] = '{
		536870912, 316933406, 167458907, 85004757,
		42667330,  21354466,  10679839,  5340245,
		2670163,   1335087,   667544,    333772,
		166886,    83443,     41722,     20861
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	vertex_t               vertex;
	logic                  done;
	point_t                pix;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	point_t screen_pts_q[$];
	int     mismatches = 0;

	longint cam_x, cam_y, shk_x, shk_y, scr_w, scr_h;

	sprite_vertex_to_screen u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.vertex   (vertex),
		.done     (done),
		.pix      (pix),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t ns mismatch: %s", $time, msg);
	endtask

	// ---------------------------------------------------------------- predictor
	function automatic void turn_to_cos_sin(input logic [15:0] ang, output longint c,
			output longint s);
		logic [15:0] a;
		longint x, y, z, dx, dy, cc, ss;
		a = ang & (16'hFFFF << (16 - TRIG_TABLE_BITS));
		if (a[13:0] == 14'd0) begin
			cc = ROT_UNIT;
			ss = 0;
		end else begin
			x = ROT_X_START;
			y = 0;
			z = longint'(a[13:0]) << 16;
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= ROT_ATAN[i];
				end else begin
					x += dx; y -= dy; z += ROT_ATAN[i];
				end
			end
			cc = x > ROT_UNIT ? ROT_UNIT : (x < -ROT_UNIT ? -ROT_UNIT : x);
			ss = y > ROT_UNIT ? ROT_UNIT : (y < -ROT_UNIT ? -ROT_UNIT : y);
		end
		case (a[15:14])
			QUAD_1: begin c = -ss; s = cc; end
			QUAD_2: begin c = -cc; s = -ss; end
			QUAD_3: begin c = ss; s = -cc; end
			default: begin c = cc; s = ss; end
		endcase
	endfunction

	function automatic logic [23:0] clamp_q16_8(input longint v);
		if (v > SCREEN_MAX)
			return COORD_MAX;
		if (v < SCREEN_MIN)
			return COORD_MIN;
		return v[23:0];
	endfunction

	function automatic point_t predict_screen(input vertex_t v);
		longint c, s, ax, ay, wx, wy, vx, vy;
		point_t p;
		turn_to_cos_sin(v.angle, c, s);
		ax = longint'($signed(v.local_x)) * longint'($signed(v.scale_x));
		ay = longint'($signed(v.local_y)) * longint'($signed(v.scale_y));
		wx = ((ax * c - ay * s + ROUND_HALF) >>> 22) + longint'($signed(v.pos_x));
		wy = ((ax * s + ay * c + ROUND_HALF) >>> 22) + longint'($signed(v.pos_y));
		vx = wx - (cam_x + shk_x);
		vy = wy - (cam_y + shk_y);
		p.screen_x = clamp_q16_8(vx);
		p.screen_y = clamp_q16_8((scr_h << 8) - vy);
		return p;
	endfunction

	function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_CAMERA_X:      cam_x = longint'($signed(data));
			REG_CAMERA_Y:      cam_y = longint'($signed(data));
			REG_SHAKE_X:       shk_x = longint'($signed(data));
			REG_SHAKE_Y:       shk_y = longint'($signed(data));
			REG_SCREEN_WIDTH:  scr_w = longint'(data[11:0]);
			REG_SCREEN_HEIGHT: scr_h = longint'(data[11:0]);
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- stimulus
	function automatic logic [23:0] rand_coord();
		logic [16:0] near;
		near = 17'($urandom);
		case ($urandom_range(9))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2, 3: return 24'($urandom);
			default: return {{7{near[16]}}, near};
		endcase
	endfunction

	function automatic logic [15:0] rand_scale();
		logic [9:0] near;
		near = 10'($urandom);
		case ($urandom_range(9))
			0: return SCALE_MAX;
			1: return SCALE_MIN;
			2: return 16'($urandom);
			3: return SCALE_ONE;
			default: return {{6{near[9]}}, near};
		endcase
	endfunction

	function automatic vertex_t rand_vertex();
		vertex_t v;
		v.local_x = rand_coord();
		v.local_y = rand_coord();
		v.scale_x = rand_scale();
		v.scale_y = rand_scale();
		if ($urandom_range(3) == 0)
			v.angle = {2'($urandom), 8'd0, 6'($urandom)};
		else
			v.angle = 16'($urandom);
		v.pos_x = rand_coord();
		v.pos_y = rand_coord();
		return v;
	endfunction

	function automatic vertex_t mk_vertex(input logic [23:0] lx, input logic [23:0] ly,
			input logic [15:0] sx, input logic [15:0] sy, input logic [15:0] ang,
			input logic [23:0] px, input logic [23:0] py);
		vertex_t v;
		v.local_x = lx;
		v.local_y = ly;
		v.scale_x = sx;
		v.scale_y = sy;
		v.angle   = ang;
		v.pos_x   = px;
		v.pos_y   = py;
		return v;
	endfunction

	// Called and returns just after a falling edge; start is left high.
	task automatic send_vertex(input vertex_t v);
		start  <= 1'b1;
		vertex <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		screen_pts_q.push_back(predict_screen(v));
		@(negedge clk);
	endtask

	task automatic sender_gap(input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic send_random(input int n, input int idle_pct);
		repeat (n) begin
			sender_gap(idle_pct);
			send_vertex(rand_vertex());
		end
	endtask

	// Hold start low until every expected point has come back or the wait limit runs out.
	task automatic drain();
		int waited;
		start  <= 1'b0;
		waited = 0;
		while (screen_pts_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		while (screen_pts_q.size() != 0) begin
			report_mismatch($sformatf("missing point, expected x %0d y %0d",
				$signed(screen_pts_q[0].screen_x), $signed(screen_pts_q[0].screen_y)));
			void'(screen_pts_q.pop_front());
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(negedge clk);
		store_reg(idx, data);
	endtask

	task automatic set_view(input logic [23:0] cx, input logic [23:0] cy,
			input logic [23:0] sx, input logic [23:0] sy, input logic [23:0] w,
			input logic [23:0] h);
		drain();
		write_reg(REG_CAMERA_X, cx);
		write_reg(REG_CAMERA_Y, cy);
		write_reg(REG_SHAKE_X, sx);
		write_reg(REG_SHAKE_Y, sy);
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
		write_reg(REG_UNUSED_6, 24'($urandom));
		write_reg(REG_UNUSED_7, 24'($urandom));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------- tests
	task automatic test_directed();
		send_vertex(mk_vertex(0, 0, 0, 0, 0, 0, 0));
		send_vertex(mk_vertex(25728, -832, SCALE_ONE, SCALE_ONE, 0, 0, 0));
		send_vertex(mk_vertex(2560, 1280, SCALE_ONE, SCALE_ONE, 16'h4000, 0, 0));
		send_vertex(mk_vertex(2560, 1280, SCALE_ONE, SCALE_ONE, 16'h8000, 0, 0));
		send_vertex(mk_vertex(2560, 1280, SCALE_ONE, SCALE_ONE, 16'hC000, 0, 0));
		send_vertex(mk_vertex(2560, 1280, SCALE_ONE, SCALE_ONE, 16'h2000, 1000, -1000));
		send_vertex(mk_vertex(2560, 1280, SCALE_ONE, SCALE_ONE, 16'h003F, 0, 0));
		send_vertex(mk_vertex(2560, 1280, SCALE_ONE, SCALE_ONE, 16'h0040, 0, 0));
		send_vertex(mk_vertex(2560, 1280, SCALE_ONE, SCALE_ONE, 16'hFFFF, 0, 0));
		send_vertex(mk_vertex(2560, 1280, -256, -256, 16'h6000, 0, 0));
		send_vertex(mk_vertex(1, 0, 128, 0, 0, 0, 0));
		send_vertex(mk_vertex(-1, 0, 128, 0, 0, 0, 0));
		send_vertex(mk_vertex(0, -1, 0, 128, 16'h4000, 0, 0));
		send_vertex(mk_vertex(COORD_MAX, COORD_MAX, SCALE_MAX, SCALE_MAX, 0, 0, 0));
		send_vertex(mk_vertex(COORD_MIN, COORD_MIN, SCALE_MIN, SCALE_MIN, 0, 0, 0));
		send_vertex(mk_vertex(COORD_MIN, 0, SCALE_MAX, 0, 0, 0, 0));
		send_vertex(mk_vertex(0, 0, 0, 0, 0, COORD_MAX, COORD_MAX));
		send_vertex(mk_vertex(0, 0, 0, 0, 0, COORD_MIN, COORD_MIN));
		send_vertex(mk_vertex(COORD_MAX, COORD_MAX, SCALE_MAX, SCALE_MAX, 16'hFFFF,
			COORD_MAX, COORD_MAX));
		send_vertex(mk_vertex(COORD_MIN, COORD_MIN, SCALE_MIN, SCALE_MIN, 16'h8000,
			COORD_MIN, COORD_MIN));
		send_vertex(mk_vertex(COORD_MAX, COORD_MIN, SCALE_MIN, SCALE_MAX, 16'hA000,
			COORD_MAX, COORD_MIN));
	endtask

	task automatic test_view_extremes();
		set_view(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 24'd4095, 24'd4095);
		send_random(20, 0);
		set_view(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 24'd1, 24'd1);
		send_random(20, 0);
		set_view(0, 0, 0, 0, 24'd1280, 24'd0);
		send_random(20, 0);
		set_view(24'd2560, -24'd1280, 24'd3, -24'd3, 24'hFFF000, 24'hABC1E0);
		send_random(20, 0);
		set_view(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 24'd0,
			24'hFFFFFF);
		send_random(20, 0);
	endtask

	task automatic test_random_views(input int idle_pct);
		repeat (3) begin
			set_view(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				24'($urandom), 24'($urandom));
			send_random(186, idle_pct);
		end
	endtask

	task automatic test_pause_and_resume();
		send_random(30, 0);
		drain();
		send_random(30, 9);
	endtask

	// ---------------------------------------------------------------- checker
	always @(posedge clk) begin : check_points
		point_t want;
		if (arst_n && done) begin
			if (screen_pts_q.size() == 0) begin
				report_mismatch($sformatf("unexpected point x %0d y %0d",
					$signed(pix.screen_x), $signed(pix.screen_y)));
			end else begin
				want = screen_pts_q.pop_front();
				if (pix.screen_x !== want.screen_x)
					report_mismatch($sformatf("screen_x got %0d want %0d",
						$signed(pix.screen_x), $signed(want.screen_x)));
				if (pix.screen_y !== want.screen_y)
					report_mismatch($sformatf("screen_y got %0d want %0d",
						$signed(pix.screen_y), $signed(want.screen_y)));
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		start    = 1'b0;
		vertex   = '0;
		cfg_we   = 1'b0;
		cfg_idx  = '0;
		cfg_data = '0;
		cam_x = 0;
		cam_y = 0;
		shk_x = 0;
		shk_y = 0;
		scr_w = 1280;
		scr_h = 720;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_view_extremes();
		test_random_views(0);
		test_random_views(51);
		test_random_views(9);
		test_pause_and_resume();

		drain();
		repeat (FLUSH_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: filelist.f
rtl/svs_pkg.sv
rtl/sprite_vertex_to_screen.sv
bench/sprite_vertex_to_screen_tb.sv
